@@ rtl/core/dsfr_pkg.sv @@
// Shared types, codes and constants of the framed byte receiver.
package dsfr_pkg;

	localparam int FRAME_SLOTS_DEF     = 8;
	localparam int MAX_FRAME_BYTES_DEF = 255;
	localparam int SLOT_SPAN           = 256;
	localparam int QUEUE_DEPTH         = 4;

	localparam logic [7:0] ESCAPE_RESET = 8'd16;
	localparam logic [7:0] START_RESET  = 8'd2;
	localparam logic [7:0] END_RESET    = 8'd3;

	localparam logic [1:0] REG_ESCAPE = 2'd0;
	localparam logic [1:0] REG_START  = 2'd1;
	localparam logic [1:0] REG_END    = 2'd2;

	localparam logic OP_RECEIVE = 1'b0;
	localparam logic OP_READ    = 1'b1;

	typedef enum logic [2:0] {
		ST_NONE     = 3'd0,
		ST_STORED   = 3'd1,
		ST_MISMATCH = 3'd2,
		ST_TOO_LONG = 3'd3,
		ST_FULL     = 3'd4,
		ST_READ     = 3'd5,
		ST_EMPTY    = 3'd6
	} status_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] line_byte;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] data_byte;
		logic       last_of_frame;
		logic [3:0] frames_pending;
	} rsp_t;

	typedef struct packed {
		status_t    status;
		logic       use_mem;
		logic       last_of_frame;
		logic [3:0] frames_pending;
	} desc_t;

endpackage

@@ rtl/core/dle_stx_etx_frame_receiver.sv @@
// Top level of the DLE STX/ETX frame receiver with XOR block check and frame ring.
// Usage: each request on the req channel carries an opcode and a line byte.
// Opcode receive feeds one serial byte to the framing parser; opcode read
// returns the next byte of the oldest stored frame. Every request produces
// exactly one result on the rsp channel, in request order, carrying a status,
// the read byte, an end-of-frame flag and the number of frames in the ring.
// Both channels use valid/ready; the cfg port writes the escape, start and
// end codes and should only be used while no request is outstanding.
// An accepted request passes first through the parser and ring update together
// with the registered frame memory read, then through result assembly into
// the output queue, before its result can be taken. Throughput is one request
// per cycle, limited by the four-entry output queue credit.
// When the rsp side stalls, requests keep being accepted until the output
// queue and the assembly stage together hold four results, then req_ready
// drops until results are taken.
// After reset the ring is empty, the parser is idle and the codes are 16, 2
// and 3. Frame memory contents are not cleared; only written bytes are read.
module dle_stx_etx_frame_receiver import dsfr_pkg::*; #(
	parameter int FRAME_SLOTS     = FRAME_SLOTS_DEF,
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic [1:0] cfg_idx,
	input  logic [7:0] cfg_wdata,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req_data,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp_data
);

	localparam int ADDR_W = $clog2(FRAME_SLOTS) + 8;

	logic              credit_ok;
	logic              desc_valid;
	desc_t             desc;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [7:0]        mem_wdata, mem_rdata;

	dsfr_front #(
		.FRAME_SLOTS    (FRAME_SLOTS),
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.credit_ok (credit_ok),
		.desc_valid(desc_valid),
		.desc      (desc),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr)
	);

	dsfr_store #(
		.FRAME_SLOTS(FRAME_SLOTS)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	dsfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.desc_valid(desc_valid),
		.desc      (desc),
		.mem_rdata (mem_rdata),
		.credit_ok (credit_ok),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

@@ rtl/core/dsfr_store.sv @@
// Frame byte memory with one write port and one registered read port.
module dsfr_store import dsfr_pkg::*; #(
	parameter int FRAME_SLOTS = FRAME_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(FRAME_SLOTS)+7:0]    waddr,
	input  logic [7:0]                        wdata,
	input  logic                              re,
	input  logic [$clog2(FRAME_SLOTS)+7:0]    raddr,
	output logic [7:0]                        rdata
);

	localparam int DEPTH = FRAME_SLOTS * SLOT_SPAN;

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/dsfr_front.sv @@
// Front end: configuration, request classification, frame parser and ring control.
module dsfr_front import dsfr_pkg::*; #(
	parameter int FRAME_SLOTS     = FRAME_SLOTS_DEF,
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [1:0]                     cfg_idx,
	input  logic [7:0]                     cfg_wdata,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  req_t                           req_data,
	input  logic                           credit_ok,
	output logic                           desc_valid,
	output desc_t                          desc,
	output logic                           mem_we,
	output logic [$clog2(FRAME_SLOTS)+7:0] mem_waddr,
	output logic [7:0]                     mem_wdata,
	output logic                           mem_re,
	output logic [$clog2(FRAME_SLOTS)+7:0] mem_raddr
);

	localparam int SLOT_W = $clog2(FRAME_SLOTS);
	localparam int USED_W = $clog2(FRAME_SLOTS + 1);

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_WAIT_START = 3'd1,
		PH_DATA       = 3'd2,
		PH_AFTER_ESC  = 3'd3,
		PH_WAIT_CHECK = 3'd4
	} phase_t;

	logic [7:0]        escape_q, start_q, end_q;
	phase_t            phase_q, phase_d;
	logic [7:0]        check_q, check_d;
	logic [7:0]        bytes_q, bytes_d;
	logic              lost_q, lost_d;
	logic [SLOT_W-1:0] wslot_q, wslot_d, rslot_q, rslot_d;
	logic [USED_W-1:0] used_q, used_d;
	logic [7:0]        offset_q, offset_d;
	logic [7:0]        lengths_q [FRAME_SLOTS];

	logic              fire, take, store_len, use_mem, last;
	status_t           st;
	logic [7:0]        ch, len;
	logic [USED_W+3:0] used_ext;

	assign fire      = req_valid && credit_ok;
	assign req_ready = credit_ok;
	assign ch        = req_data.line_byte;
	assign len       = lengths_q[rslot_q];

	always_comb begin
		phase_d   = phase_q;
		check_d   = check_q;
		bytes_d   = bytes_q;
		lost_d    = lost_q;
		wslot_d   = wslot_q;
		rslot_d   = rslot_q;
		used_d    = used_q;
		offset_d  = offset_q;
		st        = ST_NONE;
		take      = 1'b0;
		store_len = 1'b0;
		use_mem   = 1'b0;
		last      = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		if (fire && req_data.opcode == OP_RECEIVE) begin
			unique case (phase_q)
				PH_IDLE: begin
					check_d = 8'd0;
					bytes_d = 8'd0;
					lost_d  = 1'b0;
					if (ch == escape_q) begin
						phase_d = PH_WAIT_START;
					end
				end
				PH_WAIT_START: begin
					phase_d = (ch == start_q) ? PH_DATA : PH_IDLE;
				end
				PH_DATA: begin
					if (ch == escape_q) begin
						phase_d = PH_AFTER_ESC;
					end else begin
						take = 1'b1;
					end
				end
				PH_AFTER_ESC: begin
					priority if (ch == escape_q) begin
						phase_d = PH_DATA;
						take    = 1'b1;
					end else if (ch == end_q) begin
						check_d = check_q ^ ch;
						phase_d = PH_WAIT_CHECK;
					end else if (ch == start_q) begin
						check_d = 8'd0;
						bytes_d = 8'd0;
						lost_d  = 1'b0;
						phase_d = PH_DATA;
					end else begin
						check_d = 8'd0;
						bytes_d = 8'd0;
						lost_d  = 1'b0;
						phase_d = PH_IDLE;
					end
				end
				PH_WAIT_CHECK: begin
					priority if (check_q != ch) begin
						st = ST_MISMATCH;
					end else if (lost_q || used_q >= USED_W'(FRAME_SLOTS)) begin
						st = ST_FULL;
					end else begin
						store_len = 1'b1;
						wslot_d   = (wslot_q == SLOT_W'(FRAME_SLOTS - 1)) ?
							'0 : wslot_q + SLOT_W'(1);
						used_d    = used_q + USED_W'(1);
						st        = ST_STORED;
					end
					check_d = 8'd0;
					bytes_d = 8'd0;
					lost_d  = 1'b0;
					phase_d = PH_IDLE;
				end
				default: begin
					check_d = 8'd0;
					bytes_d = 8'd0;
					lost_d  = 1'b0;
					phase_d = PH_IDLE;
				end
			endcase
			if (take) begin
				if (bytes_q >= 8'(MAX_FRAME_BYTES)) begin
					check_d = 8'd0;
					bytes_d = 8'd0;
					lost_d  = 1'b0;
					phase_d = PH_IDLE;
					st      = ST_TOO_LONG;
				end else begin
					if (used_q < USED_W'(FRAME_SLOTS)) begin
						mem_we = 1'b1;
					end else begin
						lost_d = 1'b1;
					end
					check_d = check_q ^ ch;
					bytes_d = bytes_q + 8'd1;
				end
			end
		end else if (fire) begin
			if (used_q == '0) begin
				st = ST_EMPTY;
			end else begin
				st      = ST_READ;
				use_mem = offset_q < len;
				mem_re  = use_mem;
				if ({1'b0, offset_q} + 9'd1 >= {1'b0, len}) begin
					last     = 1'b1;
					rslot_d  = (rslot_q == SLOT_W'(FRAME_SLOTS - 1)) ?
						'0 : rslot_q + SLOT_W'(1);
					used_d   = used_q - USED_W'(1);
					offset_d = 8'd0;
				end else begin
					offset_d = offset_q + 8'd1;
				end
			end
		end
	end

	assign mem_waddr = {wslot_q, bytes_q};
	assign mem_wdata = ch;
	assign mem_raddr = {rslot_q, offset_q};
	assign used_ext  = {4'd0, used_d};

	assign desc_valid          = fire;
	assign desc.status         = st;
	assign desc.use_mem        = use_mem;
	assign desc.last_of_frame  = last;
	assign desc.frames_pending = used_ext[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= ESCAPE_RESET;
			start_q  <= START_RESET;
			end_q    <= END_RESET;
			phase_q  <= PH_IDLE;
			check_q  <= 8'd0;
			bytes_q  <= 8'd0;
			lost_q   <= 1'b0;
			wslot_q  <= '0;
			rslot_q  <= '0;
			used_q   <= '0;
			offset_q <= 8'd0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_idx)
					REG_ESCAPE: escape_q <= cfg_wdata;
					REG_START:  start_q  <= cfg_wdata;
					REG_END:    end_q    <= cfg_wdata;
					default: ;
				endcase
			end
			phase_q  <= phase_d;
			check_q  <= check_d;
			bytes_q  <= bytes_d;
			lost_q   <= lost_d;
			wslot_q  <= wslot_d;
			rslot_q  <= rslot_d;
			used_q   <= used_d;
			offset_q <= offset_d;
		end
	end

	always_ff @(posedge clk) begin
		if (store_len) begin
			lengths_q[wslot_q] <= bytes_q;
		end
	end

	// The ring never claims more frames than it has slots.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(FRAME_SLOTS))
		else $error("slot count exceeds ring size");

	// A frame that is being collected never grows past the length limit.
	a_bytes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_q <= 8'(MAX_FRAME_BYTES))
		else $error("frame byte count exceeds limit");

endmodule

@@ rtl/core/dsfr_back.sv @@
// Back end: result assembly stage and output queue.
module dsfr_back import dsfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       desc_valid,
	input  desc_t      desc,
	input  logic [7:0] mem_rdata,
	output logic       credit_ok,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic             valid_s2;
	desc_t            desc_s2;
	rsp_t             fifo_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W:0]   demand;
	logic             push, pop;
	rsp_t             entry;

	assign push      = valid_s2;
	assign pop       = rsp_valid && rsp_ready;
	assign rsp_valid = count_q != '0;
	assign rsp_data  = fifo_q[rd_ptr_q];
	assign demand    = {1'b0, count_q} + {{CNT_W{1'b0}}, valid_s2};
	assign credit_ok = demand < (CNT_W + 1)'(QUEUE_DEPTH);

	assign entry.status         = desc_s2.status;
	assign entry.data_byte      = desc_s2.use_mem ? mem_rdata : 8'd0;
	assign entry.last_of_frame  = desc_s2.last_of_frame;
	assign entry.frames_pending = desc_s2.frames_pending;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			valid_s2 <= desc_valid;
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (desc_valid) begin
			desc_s2 <= desc;
		end
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	// A result leaving the assembly stage always finds room in the queue.
	a_room_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> count_q < CNT_W'(QUEUE_DEPTH))
		else $error("output queue overflow");

	// A request taken from the front is assembled in the following cycle.
	a_desc_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(desc_valid && credit_ok) |=> valid_s2)
		else $error("accepted request lost before assembly");

endmodule
